@@ src/bpc_pkg.sv @@
package bpc_pkg;

    localparam int DEF_BUTTONS   = 5;
    localparam int DEF_TIME_BITS = 32;

    localparam int TICK_W     = 32;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 5;
    localparam int PIN_W      = 8;
    localparam int MODES_W    = 10;
    localparam int PINS_W     = 40;
    localparam int BCOUNT_W   = 3;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int BTN_W      = 3;
    localparam int PCOUNT_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BCOUNT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODES       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PINS        = 3'd6;

    localparam logic [TICK_W-1:0]   RST_DEBOUNCE    = 32'd50000;
    localparam logic [TICK_W-1:0]   RST_LONG_PRESS  = 32'd1000000;
    localparam logic [TICK_W-1:0]   RST_WINDOW      = 32'd500000;
    localparam logic                RST_ACTIVE_HIGH = 1'b1;
    localparam logic [BCOUNT_W-1:0] RST_BCOUNT      = 3'd5;
    localparam logic [MODES_W-1:0]  RST_MODES       = 10'd0;
    localparam logic [PINS_W-1:0]   RST_PINS        = 40'd0;

    localparam logic [MODE_W-1:0] MODE_POLL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RISE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

    localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = 8'd255;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BTN_W-1:0]  button;
    } event_t;

endpackage

@@ src/bpc_ram.sv @@
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/button_press_classifier.sv @@
// Button press classifier for up to BUTTONS buttons. A poll request carries the raw
// levels and the current tick count; an edge request carries the pin that fired. Each
// button keeps first, last and record time stamps in a small two-port state RAM, with
// valid bits and the press count beside them. A poll visits the buttons in use one at a
// time (read, stamp, judge and write back, then hand out its events) and reports long,
// normal and double presses on the result channel, the final event of a poll flagged by
// m_last_event. A poll is held up while the result channel stalls; an edge request only
// reads, stamps and judges its one button and hands out no events. Both are paced by the
// read-modify-write of the state RAM, one button entry at a time. Registers are written
// through cfg_we, cfg_index and cfg_data only while the block is idle: the user must keep
// to this, the block itself does not enforce it.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int BUTTONS   = DEF_BUTTONS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [TIME_BITS-1:0]  s_now,
    input  logic [LEVEL_W-1:0]    s_levels,
    input  logic [PIN_W-1:0]      s_pin_number,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIND_W-1:0]     m_event_kind,
    output logic [BTN_W-1:0]      m_button,
    output logic                  m_last_event
);

    localparam int IDX_W    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CNT_W    = BCOUNT_W + 1;
    localparam int CMP_W    = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;
    localparam int WORD_W   = 3 * TIME_BITS + PCOUNT_W;
    localparam int LAST_LSB = TIME_BITS;
    localparam int REC_LSB  = 2 * TIME_BITS;
    localparam int CNT_LSB  = 3 * TIME_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_STAMP = 3'd2;
    localparam logic [2:0] ST_JUDGE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]           state_reg, state_next;

    logic [TICK_W-1:0]    deb_reg, long_reg, win_reg;
    logic                 ah_reg;
    logic [BCOUNT_W-1:0]  bcount_reg;
    logic [MODES_W-1:0]   modes_reg;
    logic [PINS_W-1:0]    pins_reg;

    logic                 cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [LEVEL_W-1:0]   levels_reg, levels_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic [BUTTONS-1:0]   fv_reg, fv_next;
    logic [BUTTONS-1:0]   lv_reg, lv_next;
    logic [BUTTONS-1:0]   rv_reg, rv_next;
    logic [BUTTONS-1:0]   cnt_ok_reg, cnt_ok_next;

    logic [TIME_BITS-1:0] stg_first_reg, stg_first_next;
    logic [TIME_BITS-1:0] stg_last_reg, stg_last_next;
    logic [TIME_BITS-1:0] stg_rec_reg, stg_rec_next;
    logic [PCOUNT_W-1:0]  stg_cnt_reg, stg_cnt_next;
    logic                 stg_fv_reg, stg_fv_next;
    logic                 stg_lv_reg, stg_lv_next;
    logic                 stg_rv_reg, stg_rv_next;

    logic                 ev_long_reg, ev_long_next;
    logic                 ev_press_reg, ev_press_next;
    logic [KIND_W-1:0]    ev_kind_reg, ev_kind_next;

    logic                 held_valid_reg, held_valid_next;
    event_t               held_reg, held_next;

    logic                 m_valid_reg, m_valid_next;
    event_t               m_ev_reg, m_ev_next;
    logic                 m_last_reg, m_last_next;

    logic [CNT_W-1:0]     used_cnt;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;

    logic                 ram_we;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    logic [MODE_W-1:0]    cur_mode;
    logic                 cur_level;
    logic                 pressed;

    logic [TIME_BITS-1:0] quiet, hold, age;
    logic                 quiet_gt_deb, hold_gt_long, quiet_lt_win, age_gt_win;
    logic                 n_fv, n_lv, n_rv, counted;
    logic [TIME_BITS-1:0] n_rec;
    logic [PCOUNT_W-1:0]  n_cnt;
    logic                 j_long, j_press;
    logic [KIND_W-1:0]    j_kind;

    logic                 out_free;
    event_t               new_ev;

    bpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUTTONS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign used_cnt = ({1'b0, bcount_reg} > CNT_W'(BUTTONS)) ? CNT_W'(BUTTONS)
                                                              : {1'b0, bcount_reg};

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < used_cnt && PIN_W'(pins_reg >> (PIN_W * i)) == s_pin_number) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign cur_mode  = MODE_W'(modes_reg >> {idx_reg, 1'b0});
    assign cur_level = 1'(levels_reg >> idx_reg);
    assign pressed   = ah_reg ? cur_level : ~cur_level;

    assign quiet = now_reg - stg_last_reg;
    assign hold  = stg_last_reg - stg_first_reg;
    assign age   = now_reg - stg_rec_reg;

    assign quiet_gt_deb = CMP_W'(quiet) > CMP_W'(deb_reg);
    assign hold_gt_long = CMP_W'(hold) > CMP_W'(long_reg);
    assign quiet_lt_win = CMP_W'(quiet) < CMP_W'(win_reg);
    assign age_gt_win   = CMP_W'(age) > CMP_W'(win_reg);

    always_comb begin
        n_fv    = stg_fv_reg;
        n_lv    = stg_lv_reg;
        n_rv    = stg_rv_reg;
        n_rec   = stg_rec_reg;
        n_cnt   = stg_cnt_reg;
        counted = 1'b0;
        j_long  = 1'b0;
        j_press = 1'b0;
        j_kind  = KIND_NORMAL;
        if (cmd_reg == CMD_POLL) begin
            if (stg_fv_reg && stg_lv_reg && quiet_gt_deb) begin
                if (hold_gt_long) begin
                    j_long = 1'b1;
                    n_fv   = 1'b0;
                    n_lv   = 1'b0;
                end else if (quiet_lt_win) begin
                    if (stg_cnt_reg != PCOUNT_MAX) begin
                        n_cnt = stg_cnt_reg + PCOUNT_W'(1);
                    end
                    n_fv    = 1'b0;
                    n_lv    = 1'b0;
                    n_rec   = now_reg;
                    n_rv    = 1'b1;
                    counted = 1'b1;
                end
            end
            if (!counted && stg_rv_reg && stg_cnt_reg != '0 && age_gt_win) begin
                n_rv  = 1'b0;
                n_cnt = '0;
                if (stg_cnt_reg == PCOUNT_W'(1)) begin
                    j_press = 1'b1;
                    j_kind  = KIND_NORMAL;
                end else if (stg_cnt_reg == PCOUNT_W'(2)) begin
                    j_press = 1'b1;
                    j_kind  = KIND_DOUBLE;
                end
            end
        end
    end

    assign ram_we    = (state_reg == ST_JUDGE);
    assign ram_wdata = {n_cnt, n_rec, stg_last_reg, stg_first_reg};

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        levels_next     = levels_reg;
        idx_next        = idx_reg;
        fv_next         = fv_reg;
        lv_next         = lv_reg;
        rv_next         = rv_reg;
        cnt_ok_next     = cnt_ok_reg;
        stg_first_next  = stg_first_reg;
        stg_last_next   = stg_last_reg;
        stg_rec_next    = stg_rec_reg;
        stg_cnt_next    = stg_cnt_reg;
        stg_fv_next     = stg_fv_reg;
        stg_lv_next     = stg_lv_reg;
        stg_rv_next     = stg_rv_reg;
        ev_long_next    = ev_long_reg;
        ev_press_next   = ev_press_reg;
        ev_kind_next    = ev_kind_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ev_next       = m_ev_reg;
        m_last_next     = m_last_reg;
        new_ev.kind     = ev_long_reg ? KIND_LONG : ev_kind_reg;
        new_ev.button   = BTN_W'(idx_reg);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_command;
                    now_next    = s_now;
                    levels_next = s_levels;
                    if (used_cnt != '0) begin
                        if (s_command == CMD_POLL) begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end else if (hit) begin
                            idx_next   = hit_idx;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_STAMP;
            end
            ST_STAMP: begin
                stg_first_next = ram_rdata[0 +: TIME_BITS];
                stg_last_next  = ram_rdata[LAST_LSB +: TIME_BITS];
                stg_rec_next   = ram_rdata[REC_LSB +: TIME_BITS];
                stg_cnt_next   = cnt_ok_reg[idx_reg] ? ram_rdata[CNT_LSB +: PCOUNT_W] : '0;
                stg_fv_next    = fv_reg[idx_reg];
                stg_lv_next    = lv_reg[idx_reg];
                stg_rv_next    = rv_reg[idx_reg];
                if (cmd_reg == CMD_POLL) begin
                    if (pressed) begin
                        case (cur_mode)
                            MODE_RISE: begin
                                if (!fv_reg[idx_reg]) begin
                                    stg_first_next = now_reg;
                                    stg_fv_next    = 1'b1;
                                end
                            end
                            MODE_FALL: begin
                                if (fv_reg[idx_reg]) begin
                                    stg_last_next = now_reg;
                                    stg_lv_next   = 1'b1;
                                end
                            end
                            MODE_BOTH: begin
                            end
                            default: begin
                                if (!fv_reg[idx_reg]) begin
                                    stg_first_next = now_reg;
                                    stg_fv_next    = 1'b1;
                                end else begin
                                    stg_last_next = now_reg;
                                    stg_lv_next   = 1'b1;
                                end
                            end
                        endcase
                    end
                end else begin
                    case (cur_mode)
                        MODE_RISE: begin
                            if (!lv_reg[idx_reg]) begin
                                stg_last_next = now_reg;
                                stg_lv_next   = 1'b1;
                            end
                        end
                        MODE_FALL: begin
                            if (!fv_reg[idx_reg]) begin
                                stg_first_next = now_reg;
                                stg_fv_next    = 1'b1;
                            end
                        end
                        MODE_BOTH: begin
                            if (!fv_reg[idx_reg]) begin
                                stg_first_next = now_reg;
                                stg_fv_next    = 1'b1;
                            end else begin
                                stg_last_next = now_reg;
                                stg_lv_next   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                state_next = ST_JUDGE;
            end
            ST_JUDGE: begin
                fv_next[idx_reg]     = n_fv;
                lv_next[idx_reg]     = n_lv;
                rv_next[idx_reg]     = n_rv;
                cnt_ok_next[idx_reg] = 1'b1;
                ev_long_next         = j_long;
                ev_press_next        = j_press;
                ev_kind_next         = j_kind;
                state_next           = (cmd_reg == CMD_EDGE) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (ev_long_reg || ev_press_reg) begin
                    if (!held_valid_reg || out_free) begin
                        if (held_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_ev_next    = held_reg;
                            m_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_next       = new_ev;
                        if (ev_long_reg) begin
                            ev_long_next = 1'b0;
                        end else begin
                            ev_press_next = 1'b0;
                        end
                    end
                end else if (CNT_W'(idx_reg) + CNT_W'(1) < used_cnt) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_ev_next       = held_reg;
                    m_last_next     = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            deb_reg        <= RST_DEBOUNCE;
            long_reg       <= RST_LONG_PRESS;
            win_reg        <= RST_WINDOW;
            ah_reg         <= RST_ACTIVE_HIGH;
            bcount_reg     <= RST_BCOUNT;
            modes_reg      <= RST_MODES;
            pins_reg       <= RST_PINS;
            fv_reg         <= '0;
            lv_reg         <= '0;
            rv_reg         <= '0;
            cnt_ok_reg     <= '0;
            ev_long_reg    <= 1'b0;
            ev_press_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fv_reg         <= fv_next;
            lv_reg         <= lv_next;
            rv_reg         <= rv_next;
            cnt_ok_reg     <= cnt_ok_next;
            ev_long_reg    <= ev_long_next;
            ev_press_reg   <= ev_press_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEBOUNCE:    deb_reg    <= cfg_data[TICK_W-1:0];
                    REG_LONG_PRESS:  long_reg   <= cfg_data[TICK_W-1:0];
                    REG_WINDOW:      win_reg    <= cfg_data[TICK_W-1:0];
                    REG_ACTIVE_HIGH: ah_reg     <= cfg_data[0];
                    REG_BCOUNT:      bcount_reg <= cfg_data[BCOUNT_W-1:0];
                    REG_MODES:       modes_reg  <= cfg_data[MODES_W-1:0];
                    REG_PINS:        pins_reg   <= cfg_data[PINS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        levels_reg    <= levels_next;
        idx_reg       <= idx_next;
        stg_first_reg <= stg_first_next;
        stg_last_reg  <= stg_last_next;
        stg_rec_reg   <= stg_rec_next;
        stg_cnt_reg   <= stg_cnt_next;
        stg_fv_reg    <= stg_fv_next;
        stg_lv_reg    <= stg_lv_next;
        stg_rv_reg    <= stg_rv_next;
        ev_kind_reg   <= ev_kind_next;
        held_reg      <= held_next;
        m_ev_reg      <= m_ev_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_ev_reg.kind;
    assign m_button     = m_ev_reg.button;
    assign m_last_event = m_last_reg;

endmodule

@@ src/bpc_checker.sv @@
module bpc_checker
    import bpc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_event_kind,
    input logic [BTN_W-1:0]  m_button,
    input logic              m_last_event
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_button)
                                && $stable(m_last_event))
        else $error("result changed while stalled");

    // a new result only comes out of a running poll
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // a poll stays busy until its final event is out
    a_nonlast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_event |-> !s_ready)
        else $error("request accepted before the final event of a poll");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_kind (m_event_kind),
    .m_button     (m_button),
    .m_last_event (m_last_event)
);
